[hdl/spi_dac_frame_writer_assert.svh]
// assertion macros used by the frame writer core
`ifndef SPI_DAC_FRAME_WRITER_ASSERT_SVH
`define SPI_DAC_FRAME_WRITER_ASSERT_SVH

// expression holds on every clock edge out of reset
`define SDFW_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SDFW_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/sdfw_pkg.sv]
package sdfw_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_HIGH  = 3'd2,
        PH_TAIL  = 3'd3,
        PH_GUARD = 3'd4
    } phase_t;

    localparam logic [1:0] ACT_IDLE = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_INIT = 2'd2;

    localparam logic [1:0] CH_A    = 2'd0;
    localparam logic [1:0] CH_B    = 2'd1;
    localparam logic [1:0] CH_BOTH = 2'd2;

    localparam logic [2:0] ADDR_A = 3'd0;
    localparam logic [2:0] ADDR_B = 3'd1;

    localparam logic [2:0]  CMD_WRITE_UPDATE  = 3'h3;
    localparam logic [2:0]  CMD_REFERENCE     = 3'h7;
    localparam logic [15:0] REF_ENABLE_DATA   = 16'h0001;
    localparam logic [4:0]  FRAME_BITS        = 5'd24;
    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd8;

    // pin levels and status for one tick
    typedef struct packed {
        logic sync_n;
        logic sclk;
        logic din;
        logic busy_res;
        logic dropped;
    } result_t;

    function automatic logic [23:0] make_frame(input logic [2:0] cmd,
                                               input logic [2:0] addr,
                                               input logic [15:0] data);
        make_frame = {2'b00, cmd, addr, data};
    endfunction

    // zero half period behaves as one tick
    function automatic logic [7:0] load_delay(input logic [7:0] hp);
        load_delay = (hp == 8'd0) ? 8'd1 : hp;
    endfunction

endpackage

[hdl/sdfw_ifs.sv]
interface sdfw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [15:0] value;

    modport source (output valid, output action, output channel, output value, input ready);
    modport sink (input valid, input action, input channel, input value, output ready);
endinterface

interface sdfw_res_if;
    logic valid;
    logic ready;
    logic sync_n;
    logic sclk;
    logic din;
    logic busy_res;
    logic dropped;

    modport source (output valid, output sync_n, output sclk, output din,
                    output busy_res, output dropped, input ready);
    modport sink (input valid, input sync_n, input sclk, input din,
                  input busy_res, input dropped, output ready);
endinterface

[hdl/sdfw_core.sv]
`include "spi_dac_frame_writer_assert.svh"

module sdfw_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [1:0]       action,
    input  logic [1:0]       channel,
    input  logic [15:0]      value,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    output sdfw_pkg::result_t res_next
);
    import sdfw_pkg::*;

    logic [7:0]  half_period_reg;
    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_left_reg, bit_left_next;
    logic [7:0]  delay_count_reg, delay_count_next;
    logic [23:0] shift_word_reg, shift_word_next;
    logic [1:0]  frames_pending_reg, frames_pending_next;
    logic [15:0] held_code_reg, held_code_next;

    logic        is_req;
    logic        dropped;
    logic        do_adv;
    logic [7:0]  dc_dec;
    logic [7:0]  hp_load;
    logic [4:0]  bl_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            bit_left_reg       <= '0;
            delay_count_reg    <= '0;
            shift_word_reg     <= '0;
            frames_pending_reg <= '0;
            held_code_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            bit_left_reg       <= bit_left_next;
            delay_count_reg    <= delay_count_next;
            shift_word_reg     <= shift_word_next;
            frames_pending_reg <= frames_pending_next;
            held_code_reg      <= held_code_next;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        bit_left_next       = bit_left_reg;
        delay_count_next    = delay_count_reg;
        shift_word_next     = shift_word_reg;
        frames_pending_next = frames_pending_reg;
        held_code_next      = held_code_reg;
        dropped             = 1'b0;
        do_adv              = 1'b0;
        hp_load             = load_delay(half_period_reg);
        dc_dec              = (delay_count_reg != 8'd0) ? delay_count_reg - 8'd1 : 8'd0;
        bl_dec              = (bit_left_reg != 5'd0) ? bit_left_reg - 5'd1 : 5'd0;
        is_req              = (action == ACT_SET) || (action == ACT_INIT);

        if (is_req && phase_reg != PH_IDLE)
        begin
            dropped = 1'b1;
            do_adv  = 1'b1;
        end
        else if (action == ACT_SET &&
                 (channel == CH_A || channel == CH_B || channel == CH_BOTH))
        begin
            held_code_next      = value;
            frames_pending_next = (channel == CH_BOTH) ? 2'd1 : 2'd0;
            shift_word_next     = make_frame(CMD_WRITE_UPDATE,
                                             (channel == CH_B) ? ADDR_B : ADDR_A, value);
            bit_left_next       = FRAME_BITS;
            delay_count_next    = hp_load;
            phase_next          = PH_SETUP;
        end
        else if (action == ACT_INIT)
        begin
            held_code_next      = '0;
            frames_pending_next = 2'd2;
            shift_word_next     = make_frame(CMD_REFERENCE, ADDR_A, REF_ENABLE_DATA);
            bit_left_next       = FRAME_BITS;
            delay_count_next    = hp_load;
            phase_next          = PH_SETUP;
        end
        else
        begin
            do_adv = 1'b1;
        end

        if (do_adv && phase_reg != PH_IDLE)
        begin
            delay_count_next = dc_dec;
            if (dc_dec == 8'd0)
            begin
                unique case (phase_reg)
                    PH_SETUP:
                    begin
                        phase_next       = PH_HIGH;
                        delay_count_next = hp_load;
                    end
                    PH_HIGH:
                    begin
                        bit_left_next    = bl_dec;
                        delay_count_next = hp_load;
                        if (bl_dec != 5'd0)
                        begin
                            shift_word_next = {shift_word_reg[22:0], 1'b0};
                            phase_next      = PH_SETUP;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        phase_next       = PH_GUARD;
                        delay_count_next = hp_load;
                    end
                    PH_GUARD:
                    begin
                        if (frames_pending_reg != 2'd0)
                        begin
                            frames_pending_next = frames_pending_reg - 2'd1;
                            shift_word_next     = make_frame(CMD_WRITE_UPDATE,
                                (frames_pending_reg == 2'd2) ? ADDR_A : ADDR_B,
                                held_code_reg);
                            bit_left_next       = FRAME_BITS;
                            delay_count_next    = hp_load;
                            phase_next          = PH_SETUP;
                        end
                        else
                        begin
                            phase_next       = PH_IDLE;
                            shift_word_next  = '0;
                            delay_count_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next          = PH_IDLE;
                        frames_pending_next = '0;
                        delay_count_next    = '0;
                    end
                endcase
            end
        end

        res_next.sync_n   = 1'b1;
        res_next.sclk     = 1'b0;
        res_next.din      = 1'b0;
        if (phase_next == PH_SETUP || phase_next == PH_HIGH || phase_next == PH_TAIL)
        begin
            res_next.sync_n = 1'b0;
            res_next.din    = shift_word_next[23];
            res_next.sclk   = (phase_next == PH_HIGH);
        end
        res_next.busy_res = (phase_next != PH_IDLE);
        res_next.dropped  = dropped;
    end

    `SDFW_ASSERT_IMPLY(a_delay_live, clk, rst_n, phase_reg != PH_IDLE,
        delay_count_reg != 8'd0, "active phase with zero delay count")
    `SDFW_ASSERT_IMPLY(a_idle_no_pending, clk, rst_n, phase_reg == PH_IDLE,
        frames_pending_reg == 2'd0, "frames pending while idle")
    `SDFW_ASSERT_ALWAYS(a_bit_range, clk, rst_n, bit_left_reg <= FRAME_BITS,
        "bit count beyond frame length")

endmodule

[hdl/sdfw_out_stage.sv]
module sdfw_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sdfw_pkg::result_t res_next,
    output logic              take_ok,
    sdfw_res_if.source        res
);
    import sdfw_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // new item may enter when the register is empty or being drained
    assign take_ok = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= res_next;
        end
    end

    assign res.valid    = valid_reg;
    assign res.sync_n   = result_reg.sync_n;
    assign res.sclk     = result_reg.sclk;
    assign res.din      = result_reg.din;
    assign res.busy_res = result_reg.busy_res;
    assign res.dropped  = result_reg.dropped;

endmodule

[hdl/spi_dac_frame_writer.sv]
// channel  dir  payload                          moves
// cmd      in   action[1:0] channel[1:0] value   one tick of requests per item
// res      out  sync_n sclk din busy_res dropped pin levels after that tick
// cfg      in   cfg_wdata[7:0] half_period       write on cfg_we
//
// one item enters per cycle while cmd.ready is high; its result is in the output register the next cycle
// the state update is one pass of combinational logic from the frame state registers
// cmd.ready drops only while a result sits unread and res.ready is low
// reset puts the sequencer idle with half_period at 8; the result register itself is not reset
module spi_dac_frame_writer (
    input  logic       clk,
    input  logic       rst_n,
    sdfw_req_if.sink   cmd,
    sdfw_res_if.source res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import sdfw_pkg::*;

    logic    take_ok;
    logic    step;
    result_t res_next;

    // an item counts as a tick only when the handshake completes
    assign cmd.ready = take_ok;
    assign step      = cmd.valid && take_ok;

    // frame sequencer: shift word, bit and delay counters, pending frames
    sdfw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .action    (cmd.action),
        .channel   (cmd.channel),
        .value     (cmd.value),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_next  (res_next)
    );

    // result register between the sequencer and the consumer
    sdfw_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .res_next (res_next),
        .take_ok  (take_ok),
        .res      (res)
    );

endmodule
